// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: name");

// property must hold at every clock edge, reset cycles included
`define ASSERT_ANY(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed: name");

`endif

// ----- rtl/core/ifp_pkg.sv -----
package ifp_pkg;

   // default frame store depth in bytes
   localparam int FRAME_BUFFER_BYTES_DEFAULT = 32;

   // sync, type and length header bytes before the payload
   localparam int HDR_BYTES = 7;

   // header sync bytes
   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;

   // frame type codes
   localparam logic [7:0] TYPE_KEY     = 8'h00;
   localparam logic [7:0] TYPE_TOUCH   = 8'h01;
   localparam logic [7:0] TYPE_MOUSE   = 8'h02;
   localparam logic [7:0] TYPE_BUTTON  = 8'h03;
   localparam logic [7:0] TYPE_ENCODER = 8'h04;
   localparam logic [7:0] TYPE_INIT    = 8'hFF;

   // event kind codes on the result channel
   localparam logic [2:0] KIND_KEY     = 3'd0;
   localparam logic [2:0] KIND_TOUCH   = 3'd1;
   localparam logic [2:0] KIND_MOUSE   = 3'd2;
   localparam logic [2:0] KIND_BUTTON  = 3'd3;
   localparam logic [2:0] KIND_ENCODER = 3'd4;
   localparam logic [2:0] KIND_INIT    = 3'd5;
   localparam logic [2:0] KIND_LEN_ERR = 3'd6;

   // parser phases
   typedef enum logic [2:0] {
      PHASE_HUNT    = 3'd0,
      PHASE_SYNC    = 3'd1,
      PHASE_TYPE    = 3'd2,
      PHASE_LENGTH  = 3'd3,
      PHASE_PAYLOAD = 3'd4
   } phase_type;

endpackage

// ----- rtl/core/input_event_frame_parser.sv -----
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_rx_byte
// rsp     | out       | rsp_valid, rsp_ready, rsp_event_kind .. rsp_pressed_state
//
// one byte per cycle while req_ready is high; the parser step and the event decode sit
// between the parser state and the result register, so a byte can be taken every cycle.
// an event shows in the cycle after the byte that completes its frame.
// req_ready drops only while a held result is not taken; a byte is taken in
// the same cycle that the held result leaves.
// synchronous reset clears the parser state and the whole frame store.
`include "assert_macros.svh"

module input_event_frame_parser #(
   parameter int FRAME_BUFFER_BYTES = ifp_pkg::FRAME_BUFFER_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_kind,
   output logic [7:0]        rsp_key_action,
   output logic [15:0]       rsp_key_scancode,
   output logic [7:0]        rsp_key_modifier,
   output logic [7:0]        rsp_key_char,
   output logic [15:0]       rsp_pointer_x,
   output logic [15:0]       rsp_pointer_y,
   output logic [7:0]        rsp_touch_state,
   output logic signed [7:0] rsp_delta,
   output logic [7:0]        rsp_mouse_buttons,
   output logic [7:0]        rsp_button_id,
   output logic [7:0]        rsp_pressed_state
);

   localparam int CNT_W   = $clog2(FRAME_BUFFER_BYTES + 1);
   localparam int IDX_W   = $clog2(FRAME_BUFFER_BYTES);
   localparam int MAX_LEN = FRAME_BUFFER_BYTES - ifp_pkg::HDR_BYTES;
   localparam int PAY_N   = 6;
   localparam logic [CNT_W-1:0] STORE_END = CNT_W'(FRAME_BUFFER_BYTES);

   // parser state
   ifp_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]   byte_count_ff, byte_count_in;
   logic [CNT_W-1:0]   frame_total_ff, frame_total_in;
   logic [7:0]         frame_type_ff, frame_type_in;
   logic [7:0]         store_ff [FRAME_BUFFER_BYTES];

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         kind_ff, kind_in;
   logic [7:0]         key_action_ff, key_action_in;
   logic [15:0]        key_scancode_ff, key_scancode_in;
   logic [7:0]         key_modifier_ff, key_modifier_in;
   logic [7:0]         key_char_ff, key_char_in;
   logic [15:0]        pointer_x_ff, pointer_x_in;
   logic [15:0]        pointer_y_ff, pointer_y_in;
   logic [7:0]         touch_state_ff, touch_state_in;
   logic signed [7:0]  delta_ff, delta_in;
   logic [7:0]         mouse_buttons_ff, mouse_buttons_in;
   logic [7:0]         button_id_ff, button_id_in;
   logic [7:0]         pressed_state_ff, pressed_state_in;

   logic               accept;
   logic               store_we;
   logic [7:0]         rx;
   logic [7:0]         pay [PAY_N];
   logic               len_err;
   logic [CNT_W:0]     count_next;
   logic               emit;
   logic               do_decode;
   logic               decode_hit;
   logic               in_hunt;
   logic               in_payload;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rx        = req_rx_byte;

   assign count_next = {1'b0, byte_count_ff} + (CNT_W + 1)'(1);

   // payload bytes as the store holds them after this byte is written
   always_comb begin
      for (int p = 0; p < PAY_N; p++) begin
         if (store_we && byte_count_ff == CNT_W'(ifp_pkg::HDR_BYTES + p)) begin
            pay[p] = rx;
         end else begin
            pay[p] = store_ff[ifp_pkg::HDR_BYTES + p];
         end
      end
   end

   // 32-bit length against the store limit; the top length byte is this byte
   assign len_err = (store_ff[4] != 8'h00) || (store_ff[5] != 8'h00) || (rx != 8'h00) ||
                    (store_ff[3] > 8'(MAX_LEN));

   // parser step
   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      frame_total_in = frame_total_ff;
      frame_type_in  = frame_type_ff;
      store_we       = 1'b0;
      emit           = 1'b0;
      do_decode      = 1'b0;
      kind_in        = ifp_pkg::KIND_KEY;
      case (phase_ff)
         ifp_pkg::PHASE_HUNT: begin
            if (rx == ifp_pkg::SYNC_FIRST) begin
               store_we      = 1'b1;
               byte_count_in = CNT_W'(1);
               phase_in      = ifp_pkg::PHASE_SYNC;
            end
         end
         ifp_pkg::PHASE_SYNC: begin
            if (rx == ifp_pkg::SYNC_SECOND) begin
               store_we      = 1'b1;
               byte_count_in = count_next[CNT_W-1:0];
               phase_in      = ifp_pkg::PHASE_TYPE;
            end else begin
               byte_count_in = '0;
               phase_in      = ifp_pkg::PHASE_HUNT;
            end
         end
         ifp_pkg::PHASE_TYPE: begin
            store_we       = 1'b1;
            frame_type_in  = rx;
            frame_total_in = '0;
            if (rx == ifp_pkg::TYPE_INIT) begin
               byte_count_in = '0;
               phase_in      = ifp_pkg::PHASE_HUNT;
               emit          = 1'b1;
               kind_in       = ifp_pkg::KIND_INIT;
            end else begin
               byte_count_in = count_next[CNT_W-1:0];
               phase_in      = ifp_pkg::PHASE_LENGTH;
            end
         end
         ifp_pkg::PHASE_LENGTH: begin
            store_we      = 1'b1;
            byte_count_in = count_next[CNT_W-1:0];
            if (byte_count_ff == CNT_W'(ifp_pkg::HDR_BYTES - 1)) begin
               if (len_err) begin
                  byte_count_in = '0;
                  phase_in      = ifp_pkg::PHASE_HUNT;
                  emit          = 1'b1;
                  kind_in       = ifp_pkg::KIND_LEN_ERR;
               end else begin
                  frame_total_in = CNT_W'({1'b0, store_ff[3]} + 9'(ifp_pkg::HDR_BYTES));
                  if (store_ff[3] == 8'h00) begin
                     byte_count_in = '0;
                     phase_in      = ifp_pkg::PHASE_HUNT;
                     do_decode     = 1'b1;
                  end else begin
                     phase_in = ifp_pkg::PHASE_PAYLOAD;
                  end
               end
            end
         end
         ifp_pkg::PHASE_PAYLOAD: begin
            store_we      = byte_count_ff < CNT_W'(FRAME_BUFFER_BYTES);
            byte_count_in = count_next[CNT_W-1:0];
            if (count_next >= {1'b0, frame_total_ff}) begin
               byte_count_in = '0;
               phase_in      = ifp_pkg::PHASE_HUNT;
               do_decode     = 1'b1;
            end
         end
         default: begin
            byte_count_in = '0;
            phase_in      = ifp_pkg::PHASE_HUNT;
         end
      endcase
   end

   // event decode from fixed payload offsets
   always_comb begin
      key_action_in    = '0;
      key_scancode_in  = '0;
      key_modifier_in  = '0;
      key_char_in      = '0;
      pointer_x_in     = '0;
      pointer_y_in     = '0;
      touch_state_in   = '0;
      delta_in         = '0;
      mouse_buttons_in = '0;
      button_id_in     = '0;
      pressed_state_in = '0;
      decode_hit       = 1'b1;
      case (frame_type_ff)
         ifp_pkg::TYPE_KEY: begin
            key_action_in   = pay[0];
            key_scancode_in = {pay[2], pay[1]};
            key_modifier_in = pay[3];
            key_char_in     = pay[5];
         end
         ifp_pkg::TYPE_TOUCH: begin
            pointer_x_in   = {pay[1], pay[0]};
            pointer_y_in   = {pay[3], pay[2]};
            touch_state_in = pay[4];
         end
         ifp_pkg::TYPE_MOUSE: begin
            pointer_x_in     = {pay[1], pay[0]};
            pointer_y_in     = {pay[3], pay[2]};
            delta_in         = $signed(pay[4]);
            mouse_buttons_in = pay[5];
         end
         ifp_pkg::TYPE_BUTTON: begin
            button_id_in     = pay[0];
            pressed_state_in = pay[1];
         end
         ifp_pkg::TYPE_ENCODER: begin
            delta_in         = $signed(pay[0]);
            pressed_state_in = pay[1];
         end
         default: begin
            decode_hit = 1'b0;
         end
      endcase
   end

   // result valid: load on an accepted byte, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit || (do_decode && decode_hit);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // parser state and frame store
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ifp_pkg::PHASE_HUNT;
         byte_count_ff  <= '0;
         frame_total_ff <= '0;
         frame_type_ff  <= '0;
         for (int i = 0; i < FRAME_BUFFER_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else if (accept) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         frame_total_ff <= frame_total_in;
         frame_type_ff  <= frame_type_in;
         if (store_we) begin
            store_ff[byte_count_ff[IDX_W-1:0]] <= rx;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         // control events carry zero fields
         if (emit) begin
            kind_ff          <= kind_in;
            key_action_ff    <= '0;
            key_scancode_ff  <= '0;
            key_modifier_ff  <= '0;
            key_char_ff      <= '0;
            pointer_x_ff     <= '0;
            pointer_y_ff     <= '0;
            touch_state_ff   <= '0;
            delta_ff         <= '0;
            mouse_buttons_ff <= '0;
            button_id_ff     <= '0;
            pressed_state_ff <= '0;
         end else if (do_decode) begin
            kind_ff          <= frame_type_ff[2:0];
            key_action_ff    <= key_action_in;
            key_scancode_ff  <= key_scancode_in;
            key_modifier_ff  <= key_modifier_in;
            key_char_ff      <= key_char_in;
            pointer_x_ff     <= pointer_x_in;
            pointer_y_ff     <= pointer_y_in;
            touch_state_ff   <= touch_state_in;
            delta_ff         <= delta_in;
            mouse_buttons_ff <= mouse_buttons_in;
            button_id_ff     <= button_id_in;
            pressed_state_ff <= pressed_state_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_key_action    = key_action_ff;
   assign rsp_key_scancode  = key_scancode_ff;
   assign rsp_key_modifier  = key_modifier_ff;
   assign rsp_key_char      = key_char_ff;
   assign rsp_pointer_x     = pointer_x_ff;
   assign rsp_pointer_y     = pointer_y_ff;
   assign rsp_touch_state   = touch_state_ff;
   assign rsp_delta         = delta_ff;
   assign rsp_mouse_buttons = mouse_buttons_ff;
   assign rsp_button_id     = button_id_ff;
   assign rsp_pressed_state = pressed_state_ff;

   // phase flags for the checks below
   assign in_hunt    = (phase_ff == ifp_pkg::PHASE_HUNT);
   assign in_payload = (phase_ff == ifp_pkg::PHASE_PAYLOAD);

   // hunting always starts a frame from an empty count
   `ASSERT_ALWAYS(hunt_count_zero, clock, reset, in_hunt |-> (byte_count_ff == '0))
   // payload phase stays short of the frame end
   `ASSERT_ALWAYS(payload_in_bounds, clock, reset, in_payload |-> (byte_count_ff < frame_total_ff))
   // a frame in progress fits the store
   `ASSERT_ALWAYS(total_in_store, clock, reset, in_payload |-> (frame_total_ff <= STORE_END))
   // no byte is taken while a held result waits for rsp_ready
   `ASSERT_ALWAYS(no_overwrite, clock, reset, (rsp_valid_ff && !rsp_ready) |-> !accept)
   // a shown result carries a defined event kind
   `ASSERT_ALWAYS(kind_defined, clock, reset, rsp_valid_ff |-> (kind_ff <= ifp_pkg::KIND_LEN_ERR))

endmodule

// ----- tb/sv/input_event_checker.sv -----
`timescale 1ns / 1ps

module input_event_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [2:0]        rsp_event_kind,
   input  logic [7:0]        rsp_key_action,
   input  logic [15:0]       rsp_key_scancode,
   input  logic [7:0]        rsp_key_modifier,
   input  logic [7:0]        rsp_key_char,
   input  logic [15:0]       rsp_pointer_x,
   input  logic [15:0]       rsp_pointer_y,
   input  logic [7:0]        rsp_touch_state,
   input  logic signed [7:0] rsp_delta,
   input  logic [7:0]        rsp_mouse_buttons,
   input  logic [7:0]        rsp_button_id,
   input  logic [7:0]        rsp_pressed_state,
   output int                mismatch_count,
   output int                pending_events
);

   localparam int STORE_BYTES  = ifp_pkg::FRAME_BUFFER_BYTES_DEFAULT;
   localparam int HDR_BYTES    = ifp_pkg::HDR_BYTES;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  key_action;
      logic [15:0] key_scancode;
      logic [7:0]  key_modifier;
      logic [7:0]  key_char;
      logic [15:0] pointer_x;
      logic [15:0] pointer_y;
      logic [7:0]  touch_state;
      logic [7:0]  delta;
      logic [7:0]  mouse_buttons;
      logic [7:0]  button_id;
      logic [7:0]  pressed_state;
   } input_event_type;

   // parser state mirrored from the block
   ifp_pkg::phase_type phase;
   int                 byte_count;
   int                 frame_total;
   logic [7:0]         frame_type;
   logic [7:0]         frame_store [STORE_BYTES];
   input_event_type    expected_events [$];

   initial begin
      mismatch_count = 0;
      pending_events = 0;
   end

   function automatic logic [7:0] payload_byte(input int offset);
      return frame_store[HDR_BYTES + offset];
   endfunction

   function automatic void store_byte(input logic [7:0] value);
      if (byte_count < STORE_BYTES) begin
         frame_store[byte_count] = value;
      end
      byte_count++;
   endfunction

   function automatic void back_to_hunt();
      phase      = ifp_pkg::PHASE_HUNT;
      byte_count = 0;
   endfunction

   // fields at fixed payload offsets; unknown types give no event
   function automatic bit decode_event(output input_event_type ev);
      ev = '0;
      decode_event = 1'b1;
      case (frame_type)
         ifp_pkg::TYPE_KEY: begin
            ev.kind         = ifp_pkg::KIND_KEY;
            ev.key_action   = payload_byte(0);
            ev.key_scancode = {payload_byte(2), payload_byte(1)};
            ev.key_modifier = payload_byte(3);
            ev.key_char     = payload_byte(5);
         end
         ifp_pkg::TYPE_TOUCH: begin
            ev.kind        = ifp_pkg::KIND_TOUCH;
            ev.pointer_x   = {payload_byte(1), payload_byte(0)};
            ev.pointer_y   = {payload_byte(3), payload_byte(2)};
            ev.touch_state = payload_byte(4);
         end
         ifp_pkg::TYPE_MOUSE: begin
            ev.kind          = ifp_pkg::KIND_MOUSE;
            ev.pointer_x     = {payload_byte(1), payload_byte(0)};
            ev.pointer_y     = {payload_byte(3), payload_byte(2)};
            ev.delta         = payload_byte(4);
            ev.mouse_buttons = payload_byte(5);
         end
         ifp_pkg::TYPE_BUTTON: begin
            ev.kind          = ifp_pkg::KIND_BUTTON;
            ev.button_id     = payload_byte(0);
            ev.pressed_state = payload_byte(1);
         end
         ifp_pkg::TYPE_ENCODER: begin
            ev.kind          = ifp_pkg::KIND_ENCODER;
            ev.delta         = payload_byte(0);
            ev.pressed_state = payload_byte(1);
         end
         default: begin
            decode_event = 1'b0;
         end
      endcase
   endfunction

   // one parser step per accepted byte; returns 1 when an event is due
   function automatic bit parse_byte(input logic [7:0] rx, output input_event_type ev);
      logic [31:0] length_field;
      ev = '0;
      parse_byte = 1'b0;
      case (phase)
         ifp_pkg::PHASE_HUNT: begin
            if (rx == ifp_pkg::SYNC_FIRST) begin
               byte_count = 0;
               store_byte(rx);
               phase = ifp_pkg::PHASE_SYNC;
            end
         end
         ifp_pkg::PHASE_SYNC: begin
            if (rx == ifp_pkg::SYNC_SECOND) begin
               store_byte(rx);
               phase = ifp_pkg::PHASE_TYPE;
            end else begin
               back_to_hunt();
            end
         end
         ifp_pkg::PHASE_TYPE: begin
            store_byte(rx);
            frame_type  = rx;
            frame_total = 0;
            if (rx == ifp_pkg::TYPE_INIT) begin
               back_to_hunt();
               ev.kind    = ifp_pkg::KIND_INIT;
               parse_byte = 1'b1;
            end else begin
               phase = ifp_pkg::PHASE_LENGTH;
            end
         end
         ifp_pkg::PHASE_LENGTH: begin
            store_byte(rx);
            if (byte_count == HDR_BYTES) begin
               length_field = {frame_store[6], frame_store[5], frame_store[4], frame_store[3]};
               if (length_field > STORE_BYTES - HDR_BYTES) begin
                  back_to_hunt();
                  ev.kind    = ifp_pkg::KIND_LEN_ERR;
                  parse_byte = 1'b1;
               end else begin
                  frame_total = int'(length_field) + HDR_BYTES;
                  if (length_field == 0) begin
                     back_to_hunt();
                     parse_byte = decode_event(ev);
                  end else begin
                     phase = ifp_pkg::PHASE_PAYLOAD;
                  end
               end
            end
         end
         ifp_pkg::PHASE_PAYLOAD: begin
            store_byte(rx);
            if (byte_count >= frame_total) begin
               back_to_hunt();
               parse_byte = decode_event(ev);
            end
         end
         default: begin
            back_to_hunt();
         end
      endcase
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
         end
      end
   endtask

   // compare taken events first, then predict from the byte taken at this edge
   always @(posedge clock) begin : event_check
      input_event_type want;
      input_event_type next_event;
      if (reset) begin
         back_to_hunt();
         frame_total = 0;
         frame_type  = '0;
         foreach (frame_store[i]) begin
            frame_store[i] = '0;
         end
         expected_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected event of kind %0d", rsp_event_kind);
               end
            end else begin
               want = expected_events.pop_front();
               check_field("event_kind", want.kind, rsp_event_kind);
               check_field("key_action", want.key_action, rsp_key_action);
               check_field("key_scancode", want.key_scancode, rsp_key_scancode);
               check_field("key_modifier", want.key_modifier, rsp_key_modifier);
               check_field("key_char", want.key_char, rsp_key_char);
               check_field("pointer_x", want.pointer_x, rsp_pointer_x);
               check_field("pointer_y", want.pointer_y, rsp_pointer_y);
               check_field("touch_state", want.touch_state, rsp_touch_state);
               check_field("delta", want.delta, $unsigned(rsp_delta));
               check_field("mouse_buttons", want.mouse_buttons, rsp_mouse_buttons);
               check_field("button_id", want.button_id, rsp_button_id);
               check_field("pressed_state", want.pressed_state, rsp_pressed_state);
            end
         end
         if (req_valid && req_ready) begin
            if (parse_byte(req_rx_byte, next_event)) begin
               expected_events.push_back(next_event);
            end
         end
      end
      pending_events <= expected_events.size();
   end

endmodule

// ----- tb/sv/input_event_frame_parser_test.sv -----
`timescale 1ns / 1ps

module input_event_frame_parser_test;

   localparam int STREAM_BYTES    = 750;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_PAYLOAD     = ifp_pkg::FRAME_BUFFER_BYTES_DEFAULT - ifp_pkg::HDR_BYTES;

   localparam logic [7:0] SYNC_A = ifp_pkg::SYNC_FIRST;
   localparam logic [7:0] SYNC_B = ifp_pkg::SYNC_SECOND;

   // header corner cases, init request, length one past the limit,
   // zero length over a cleared store, encoder with extreme bytes
   localparam logic [7:0] DIRECTED_BYTES [30] = '{
      8'h12, SYNC_A, SYNC_A, SYNC_B,
      SYNC_A, SYNC_B, ifp_pkg::TYPE_INIT,
      SYNC_A, SYNC_B, ifp_pkg::TYPE_MOUSE, 8'(MAX_PAYLOAD + 1), 8'h00, 8'h00, 8'h00,
      SYNC_A, SYNC_B, ifp_pkg::TYPE_KEY, 8'h00, 8'h00, 8'h00, 8'h00,
      SYNC_A, SYNC_B, ifp_pkg::TYPE_ENCODER, 8'h02, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF
   };

   localparam logic [7:0] KNOWN_TYPES [5] = '{
      ifp_pkg::TYPE_KEY, ifp_pkg::TYPE_TOUCH, ifp_pkg::TYPE_MOUSE,
      ifp_pkg::TYPE_BUTTON, ifp_pkg::TYPE_ENCODER
   };

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic [7:0]        req_rx_byte = '0;
   logic              rsp_ready   = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   logic [2:0]        rsp_event_kind;
   logic [7:0]        rsp_key_action;
   logic [15:0]       rsp_key_scancode;
   logic [7:0]        rsp_key_modifier;
   logic [7:0]        rsp_key_char;
   logic [15:0]       rsp_pointer_x;
   logic [15:0]       rsp_pointer_y;
   logic [7:0]        rsp_touch_state;
   logic signed [7:0] rsp_delta;
   logic [7:0]        rsp_mouse_buttons;
   logic [7:0]        rsp_button_id;
   logic [7:0]        rsp_pressed_state;

   int mismatch_count;
   int pending_events;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int bytes_sent     = 0;
   bit stall_receiver = 1'b0;

   input_event_frame_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_key_action    (rsp_key_action),
      .rsp_key_scancode  (rsp_key_scancode),
      .rsp_key_modifier  (rsp_key_modifier),
      .rsp_key_char      (rsp_key_char),
      .rsp_pointer_x     (rsp_pointer_x),
      .rsp_pointer_y     (rsp_pointer_y),
      .rsp_touch_state   (rsp_touch_state),
      .rsp_delta         (rsp_delta),
      .rsp_mouse_buttons (rsp_mouse_buttons),
      .rsp_button_id     (rsp_button_id),
      .rsp_pressed_state (rsp_pressed_state)
   );

   input_event_checker u_event_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_key_action    (rsp_key_action),
      .rsp_key_scancode  (rsp_key_scancode),
      .rsp_key_modifier  (rsp_key_modifier),
      .rsp_key_char      (rsp_key_char),
      .rsp_pointer_x     (rsp_pointer_x),
      .rsp_pointer_y     (rsp_pointer_y),
      .rsp_touch_state   (rsp_touch_state),
      .rsp_delta         (rsp_delta),
      .rsp_mouse_buttons (rsp_mouse_buttons),
      .rsp_button_id     (rsp_button_id),
      .rsp_pressed_state (rsp_pressed_state),
      .mismatch_count    (mismatch_count),
      .pending_events    (pending_events)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random ready, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (stall_receiver) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            stall_receiver = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // end the run when nothing moves on either channel for too long
   initial begin
      int stalled_cycles;
      stalled_cycles = 0;
      wait (!reset);
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
      end
      $display("status: fail");
      $finish;
   end

   // offer one item, with random gaps before it, and wait until it is taken
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do begin
         @(posedge clock);
      end while (!req_ready);
      bytes_sent++;
   endtask

   // header, length unless init, then sent random payload bytes
   task automatic send_frame(input logic [7:0] kind_byte, input logic [31:0] length,
                             input int sent);
      send_byte(ifp_pkg::SYNC_FIRST);
      send_byte(ifp_pkg::SYNC_SECOND);
      send_byte(kind_byte);
      if (kind_byte != ifp_pkg::TYPE_INIT) begin
         for (int i = 0; i < 4; i++) begin
            send_byte(length[8*i +: 8]);
         end
      end
      for (int i = 0; i < sent; i++) begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   // mostly well-formed frames, plus broken headers, truncation and noise
   task automatic send_random_traffic(input int byte_target);
      int          choice;
      int          pick;
      logic [31:0] length;
      while (bytes_sent < byte_target) begin
         choice = $urandom_range(99);
         if (choice < 62) begin
            pick = $urandom_range(19);
            if (pick == 0) begin
               length = MAX_PAYLOAD;
            end else if (pick < 3) begin
               length = $urandom_range(MAX_PAYLOAD);
            end else begin
               length = $urandom_range(7);
            end
            // a truncated frame swallows the start of the next one
            if ($urandom_range(19) == 0) begin
               send_frame(KNOWN_TYPES[$urandom_range(4)], length,
                          $urandom_range(int'(length)));
            end else begin
               send_frame(KNOWN_TYPES[$urandom_range(4)], length, int'(length));
            end
         end else if (choice < 68) begin
            send_frame(ifp_pkg::TYPE_INIT, '0, 0);
         end else if (choice < 75) begin
            length = $urandom_range(7);
            send_frame(8'($urandom_range(254, 5)), length, int'(length));
         end else if (choice < 82) begin
            if ($urandom_range(1) == 0) begin
               length = $urandom_range(255, MAX_PAYLOAD + 1);
            end else begin
               length = $urandom | 32'h0001_0000;
            end
            send_frame(8'($urandom_range(255)), length, $urandom_range(3));
         end else if (choice < 90) begin
            send_byte(ifp_pkg::SYNC_FIRST);
            if ($urandom_range(1) == 0) begin
               send_byte(ifp_pkg::SYNC_SECOND);
               if ($urandom_range(1) == 0) begin
                  send_byte(KNOWN_TYPES[$urandom_range(4)]);
               end
            end
            send_byte(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      send_idle_pct = 18;
      recv_idle_pct = 87;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_BYTES[i]) begin
         send_byte(DIRECTED_BYTES[i]);
      end
      send_random_traffic(STREAM_BYTES / 3);

      send_idle_pct = 87;
      recv_idle_pct = 18;
      send_random_traffic(2 * STREAM_BYTES / 3);

      // no idling; receiver holds off while items keep coming
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      stall_receiver = 1'b1;
      send_random_traffic(STREAM_BYTES);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_events != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_events == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
